FILE: src/bscd_pkg.sv
// shared constants, codes and crc helper for the byte-stuffed crc deframer
package bscd_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'h0000;
    localparam logic [1:0]  MIN_BYTES = 2'd3;
    localparam logic [1:0]  EMIT_FROM = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSTART = 2'd1,
        ST_SHORT   = 2'd2,
        ST_CRCERR  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_DATA = 3'b010,
        PH_ESC  = 3'b100
    } phase_t;

    // one byte through the reflected crc-16, lsb first
    function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: src/byte_stuffed_crc_deframer.sv
// byte-stuffed crc deframer: unstuffs frames, checks crc-16, streams payload and verdict
// Takes one received line byte per cycle unless stalled and gives at most one result per
// byte. A byte waits in the input register, where a one-hot state machine, the escape
// handling and a byte-wide crc-16 update work on it, and the result lands in the output
// register; the input register can take a new byte while its last one moves on. The
// output register is the only place that waits on out_stall, and the input side stalls
// only while that register is full and stalled. Payload bytes leave two places late, so the
// crc trailer is never passed on; each frame ends with a verdict item (end_of_frame high)
// and downstream, not this block, drops the payload of any frame whose status is not ok.
module byte_stuffed_crc_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic       end_of_frame,
    output logic [1:0] frame_status
);

    // input register
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;

    // frame state
    bscd_pkg::phase_t phase_reg;
    bscd_pkg::phase_t phase_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [7:0]       held0_reg;
    logic [7:0]       held0_next;
    logic [7:0]       held1_reg;
    logic [7:0]       held1_next;
    logic [1:0]       seen_reg;
    logic [1:0]       seen_next;

    // result register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_eof_reg;
    logic [1:0] out_status_reg;

    logic       s1_go;
    logic       fire;
    logic       accept;
    logic       res_valid;
    logic [7:0] res_byte;
    logic       res_eof;
    logic [1:0] res_status;
    logic       take;
    logic [7:0] take_byte;

    assign s1_go    = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && s1_go;
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_byte_reg;
    assign end_of_frame = out_eof_reg;
    assign frame_status = out_status_reg;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // per-byte frame logic
    always_comb
    begin
        phase_next = phase_reg;
        res_valid  = 1'b0;
        res_byte   = 8'h00;
        res_eof    = 1'b0;
        res_status = bscd_pkg::ST_OK;
        take       = 1'b0;
        take_byte  = s1_byte_reg;
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        seen_next  = seen_reg;

        unique case (phase_reg)
            bscd_pkg::PH_DATA:
            begin
                if (s1_byte_reg == bscd_pkg::ESC_BYTE)
                begin
                    phase_next = bscd_pkg::PH_ESC;
                end
                else if (s1_byte_reg == bscd_pkg::FLAG_BYTE)
                begin
                    phase_next = bscd_pkg::PH_WAIT;
                    res_valid  = 1'b1;
                    res_eof    = 1'b1;
                    if (seen_reg < bscd_pkg::MIN_BYTES)
                    begin
                        res_status = bscd_pkg::ST_SHORT;
                    end
                    else if (crc_reg != 16'h0000)
                    begin
                        res_status = bscd_pkg::ST_CRCERR;
                    end
                    else
                    begin
                        res_status = bscd_pkg::ST_OK;
                    end
                end
                else
                begin
                    take = 1'b1;
                end
            end
            bscd_pkg::PH_ESC:
            begin
                phase_next = bscd_pkg::PH_DATA;
                take       = 1'b1;
                take_byte  = s1_byte_reg ^ bscd_pkg::ESC_XOR;
            end
            default:
            begin
                if (s1_byte_reg == bscd_pkg::FLAG_BYTE)
                begin
                    phase_next = bscd_pkg::PH_DATA;
                    crc_next   = bscd_pkg::CRC_INIT;
                    held0_next = 8'h00;
                    held1_next = 8'h00;
                    seen_next  = 2'd0;
                end
                else
                begin
                    phase_next = bscd_pkg::PH_WAIT;
                    res_valid  = 1'b1;
                    res_eof    = 1'b1;
                    res_status = bscd_pkg::ST_NOSTART;
                end
            end
        endcase

        // data byte: crc, two-deep delay line, saturating count
        if (take)
        begin
            crc_next = bscd_pkg::crc_feed(crc_reg, take_byte);
            if (seen_reg >= bscd_pkg::EMIT_FROM)
            begin
                res_valid = 1'b1;
                res_byte  = held0_reg;
            end
            held0_next = held1_reg;
            held1_next = take_byte;
            if (seen_reg != 2'd3)
            begin
                seen_next = seen_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        if (fire && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= bscd_pkg::PH_WAIT;
            crc_reg       <= bscd_pkg::CRC_INIT;
            held0_reg     <= 8'h00;
            held1_reg     <= 8'h00;
            seen_reg      <= 2'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                crc_reg   <= crc_next;
                held0_reg <= held0_next;
                held1_reg <= held1_next;
                seen_reg  <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (fire && res_valid)
        begin
            out_byte_reg   <= res_byte;
            out_eof_reg    <= res_eof;
            out_status_reg <= res_status;
        end
    end

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid) |-> (!out_valid_reg || !out_stall))
    else $error("result register overwritten while stalled");

    // payload leaves only once two frame bytes are held
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && !res_eof) |-> (seen_reg >= bscd_pkg::EMIT_FROM))
    else $error("payload emitted before delay line filled");

    // a verdict always returns the block to waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && res_eof) |=> (phase_reg == bscd_pkg::PH_WAIT))
    else $error("verdict without return to waiting");

    // payload items carry an ok status and no verdict flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_eof_reg) |-> (out_status_reg == bscd_pkg::ST_OK))
    else $error("payload item with non-ok status");

endmodule

FILE: verif/byte_stuffed_crc_deframer_tb.sv
// self-checking testbench for the byte-stuffed crc deframer
`timescale 1ns / 100ps

module byte_stuffed_crc_deframer_tb;

    localparam int ITEM_TARGET  = 1350;
    localparam int NO_IDLE_UPTO = 650;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // tracks deframer state and the results still owed by the block
    class frame_scoreboard;
        typedef struct {
            logic [7:0]         data;
            logic               eof;
            bscd_pkg::status_t  status;
        } frame_result_t;

        bscd_pkg::phase_t line_phase;
        logic [15:0]      frame_crc;
        logic [7:0]       delay_line [2];
        logic [1:0]       frame_len;
        frame_result_t    owed [$];
        int               fail_count;
        int               bytes_in;
        int               payload_out;
        int               verdicts [4];

        function new();
            line_phase    = bscd_pkg::PH_WAIT;
            frame_crc     = bscd_pkg::CRC_INIT;
            delay_line[0] = 8'h00;
            delay_line[1] = 8'h00;
            frame_len     = 2'd0;
            fail_count    = 0;
            bytes_in      = 0;
            payload_out   = 0;
            foreach (verdicts[i])
            begin
                verdicts[i] = 0;
            end
        endfunction

        // reflected crc-16, one message bit folded in per step
        function logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] r;
            logic        fb;
            r = c;
            for (int i = 0; i < 8; i++)
            begin
                fb = r[0] ^ b[i];
                r  = r >> 1;
                if (fb)
                begin
                    r = r ^ bscd_pkg::CRC_POLY;
                end
            end
            return r;
        endfunction

        function void owe(input logic [7:0] data, input logic eof,
                          input bscd_pkg::status_t status);
            frame_result_t res;
            res.data   = data;
            res.eof    = eof;
            res.status = status;
            owed.push_back(res);
        endfunction

        // unstuffed byte enters crc and the two-deep delay line
        function void take_payload(input logic [7:0] b);
            frame_crc = crc16_byte(frame_crc, b);
            if (frame_len >= bscd_pkg::EMIT_FROM)
            begin
                owe(delay_line[0], 1'b0, bscd_pkg::ST_OK);
            end
            delay_line[0] = delay_line[1];
            delay_line[1] = b;
            if (frame_len != 2'd3)
            begin
                frame_len = frame_len + 2'd1;
            end
        endfunction

        function void note_input(input logic [7:0] raw);
            bytes_in++;
            case (line_phase)
                bscd_pkg::PH_DATA:
                begin
                    if (raw == bscd_pkg::ESC_BYTE)
                    begin
                        line_phase = bscd_pkg::PH_ESC;
                    end
                    else if (raw == bscd_pkg::FLAG_BYTE)
                    begin
                        line_phase = bscd_pkg::PH_WAIT;
                        if (frame_len < bscd_pkg::MIN_BYTES)
                        begin
                            owe(8'h00, 1'b1, bscd_pkg::ST_SHORT);
                        end
                        else if (frame_crc != 16'h0000)
                        begin
                            owe(8'h00, 1'b1, bscd_pkg::ST_CRCERR);
                        end
                        else
                        begin
                            owe(8'h00, 1'b1, bscd_pkg::ST_OK);
                        end
                    end
                    else
                    begin
                        take_payload(raw);
                    end
                end
                bscd_pkg::PH_ESC:
                begin
                    line_phase = bscd_pkg::PH_DATA;
                    take_payload(raw ^ bscd_pkg::ESC_XOR);
                end
                default:
                begin
                    if (raw == bscd_pkg::FLAG_BYTE)
                    begin
                        line_phase    = bscd_pkg::PH_DATA;
                        frame_crc     = bscd_pkg::CRC_INIT;
                        delay_line[0] = 8'h00;
                        delay_line[1] = 8'h00;
                        frame_len     = 2'd0;
                    end
                    else
                    begin
                        line_phase = bscd_pkg::PH_WAIT;
                        owe(8'h00, 1'b1, bscd_pkg::ST_NOSTART);
                    end
                end
            endcase
        endfunction

        function void check_result(input logic [7:0] data, input logic eof,
                                   input logic [1:0] status);
            frame_result_t res;
            if (owed.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("unexpected item: data %02h eof %0d status %0d",
                             data, eof, status);
                end
                return;
            end
            res = owed.pop_front();
            if (res.eof)
            begin
                verdicts[res.status]++;
            end
            else
            begin
                payload_out++;
            end
            if (res.data !== data || res.eof !== eof || res.status !== status)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("item mismatch: expected data %02h eof %0d status %0d,",
                             res.data, res.eof, res.status);
                    $display("               got data %02h eof %0d status %0d",
                             data, eof, status);
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] payload_byte;
    logic       end_of_frame;
    logic [1:0] frame_status;

    frame_scoreboard sb = new();

    int idle_pct  = 21;
    int stall_pct = 21;
    int bytes_sent = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    byte_stuffed_crc_deframer u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .end_of_frame (end_of_frame),
        .frame_status (frame_status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            sb.note_input(rx_byte);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(payload_byte, end_of_frame, frame_status);
        end
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return bscd_pkg::FLAG_BYTE;
            1:       return bscd_pkg::ESC_BYTE;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // called and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_stuffed(input logic [7:0] b);
        if (b == bscd_pkg::FLAG_BYTE || b == bscd_pkg::ESC_BYTE)
        begin
            send_byte(bscd_pkg::ESC_BYTE);
            send_byte(b ^ bscd_pkg::ESC_XOR);
        end
        else
        begin
            send_byte(b);
        end
    endtask

    task automatic send_frame(input logic [7:0] body [$], input bit bad_crc);
        logic [15:0] fcs;
        fcs = bscd_pkg::CRC_INIT;
        send_byte(bscd_pkg::FLAG_BYTE);
        foreach (body[i])
        begin
            fcs = sb.crc16_byte(fcs, body[i]);
            send_stuffed(body[i]);
        end
        if (bad_crc)
        begin
            fcs = fcs ^ (16'h0001 << $urandom_range(15));
        end
        // trailer goes low byte first, which leaves a zero residue
        send_stuffed(fcs[7:0]);
        send_stuffed(fcs[15:8]);
        send_byte(bscd_pkg::FLAG_BYTE);
    endtask

    task automatic send_random_chunk();
        logic [7:0] body [$];
        int         pick;
        int         len;
        pick = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
        if (pick < 70)
        begin
            for (int i = 0; i < len; i++)
            begin
                body.push_back(pick_byte());
            end
            send_frame(body, $urandom_range(3) == 0);
        end
        else if (pick < 80)
        begin
            // line noise outside any frame
            repeat ($urandom_range(1, 4))
            begin
                send_byte(pick_byte());
            end
        end
        else if (pick < 88)
        begin
            // raw bytes without stuffing, so flags and escapes land anywhere
            send_byte(bscd_pkg::FLAG_BYTE);
            repeat (len)
            begin
                send_byte(pick_byte());
            end
            send_byte(bscd_pkg::FLAG_BYTE);
        end
        else if (pick < 94)
        begin
            // frame cut off, the next flag closes it
            send_byte(bscd_pkg::FLAG_BYTE);
            repeat (len)
            begin
                send_byte(8'($urandom_range(255)));
            end
        end
        else
        begin
            // escape right before the flag swallows the flag as data
            send_byte(bscd_pkg::FLAG_BYTE);
            repeat (len)
            begin
                send_byte(8'($urandom_range(255)));
            end
            send_byte(bscd_pkg::ESC_BYTE);
            send_byte(bscd_pkg::FLAG_BYTE);
            send_byte(bscd_pkg::FLAG_BYTE);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] one_byte [$];
        repeat (9)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bytes outside a frame, the escape among them
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(bscd_pkg::ESC_BYTE);
        // empty frame, then a two-byte frame
        send_byte(bscd_pkg::FLAG_BYTE);
        send_byte(bscd_pkg::FLAG_BYTE);
        send_byte(bscd_pkg::FLAG_BYTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(bscd_pkg::FLAG_BYTE);
        // shortest good frame, its one payload byte needs stuffing
        one_byte.push_back(bscd_pkg::FLAG_BYTE);
        send_frame(one_byte, 1'b0);
        // escaped escape and escaped flag
        send_byte(bscd_pkg::FLAG_BYTE);
        send_byte(bscd_pkg::ESC_BYTE);
        send_byte(bscd_pkg::ESC_BYTE);
        send_byte(bscd_pkg::ESC_BYTE);
        send_byte(bscd_pkg::FLAG_BYTE);
        send_byte(8'hA5);
        send_byte(bscd_pkg::FLAG_BYTE);
        wait_drained();

        // long receiver hold-off while the sender keeps pushing
        hold_requests++;
        idle_pct = 0;
        repeat (40)
        begin
            send_random_chunk();
        end
        idle_pct = 21;
        wait_drained();

        idle_pct  = 0;
        stall_pct = 0;
        while (bytes_sent < NO_IDLE_UPTO)
        begin
            send_random_chunk();
        end
        idle_pct  = 21;
        stall_pct = 21;
        while (bytes_sent < ITEM_TARGET)
        begin
            send_random_chunk();
        end
        wait_drained();

        $display("sent %0d bytes; checked %0d payload bytes", sb.bytes_in, sb.payload_out);
        $display("verdicts ok %0d, no start %0d, short %0d, crc error %0d",
                 sb.verdicts[bscd_pkg::ST_OK], sb.verdicts[bscd_pkg::ST_NOSTART],
                 sb.verdicts[bscd_pkg::ST_SHORT], sb.verdicts[bscd_pkg::ST_CRCERR]);
        if (sb.fail_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("%0d failing items", sb.fail_count);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
